/* design/e2hm_pkg.sv */
// Shared constants, types and arithmetic helpers for the Euler-angle to
// homogeneous transform block. No dependencies.
package e2hm_pkg;

	localparam int CORDIC_STAGES = 14;
	localparam int ENTRY_WIDTH   = 16;

	localparam int ATAN_LEN   = 24;
	localparam int NSTG       = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
	localparam int ANGLE_W    = 16;
	localparam int SHIFT_W    = 32;
	localparam int ZW         = 34;           // Q30 datapath inside the CORDIC row
	localparam int SCW        = 32;           // Q30 sine / cosine after sign fix
	localparam int STAGE_W    = 5;
	localparam int FRAC       = ENTRY_WIDTH - 2;
	localparam int RND_SH     = 30 - FRAC;
	localparam int NLANE      = 3;

	localparam int LANE_YAW   = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_ROLL  = 2;

	localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT  = 16'sd25736;
	localparam logic signed [ZW-1:0]      Q30_PI       = 34'sd3373259426;
	localparam logic signed [ZW-1:0]      Q30_HALF_PI  = 34'sd1686629713;
	localparam logic signed [ZW-1:0]      Q30_GAIN_INV = 34'sd652032874;

	typedef struct packed {
		logic signed [ZW-1:0] x;
		logic signed [ZW-1:0] y;
		logic signed [ZW-1:0] z;
	} lane_t;

	typedef struct packed {
		lane_t [NLANE-1:0]               lane;
		logic  [NLANE-1:0]               neg;
		logic  [NLANE-1:0][SHIFT_W-1:0]  shift;
	} cordic_word_t;

	// atan(2^-i) in Q30, truncated
	function automatic logic signed [ZW-1:0] atan_q30(input logic [STAGE_W-1:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:    r = 34'sd843314856;
			5'd1:    r = 34'sd497837829;
			5'd2:    r = 34'sd263043836;
			5'd3:    r = 34'sd133525158;
			5'd4:    r = 34'sd67021686;
			5'd5:    r = 34'sd33543515;
			5'd6:    r = 34'sd16775850;
			5'd7:    r = 34'sd8388437;
			5'd8:    r = 34'sd4194282;
			5'd9:    r = 34'sd2097149;
			5'd10:   r = 34'sd1048575;
			5'd11:   r = 34'sd524287;
			5'd12:   r = 34'sd262143;
			5'd13:   r = 34'sd131071;
			5'd14:   r = 34'sd65535;
			5'd15:   r = 34'sd32767;
			5'd16:   r = 34'sd16383;
			5'd17:   r = 34'sd8191;
			5'd18:   r = 34'sd4095;
			5'd19:   r = 34'sd2047;
			5'd20:   r = 34'sd1023;
			5'd21:   r = 34'sd511;
			5'd22:   r = 34'sd255;
			5'd23:   r = 34'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q30 x Q30 product, floored back to Q30
	function automatic logic signed [SCW-1:0] qmul(input logic signed [SCW-1:0] a,
			input logic signed [SCW-1:0] b);
		logic signed [2*SCW-1:0] p;
		logic signed [2*SCW-1:0] s;
		p = a * b;
		s = p >>> 30;
		return s[SCW-1:0];
	endfunction

	// Q30 to entry format: round half up, saturate to +-1
	function automatic logic [ENTRY_WIDTH-1:0] to_entry(input logic signed [ZW-1:0] v);
		logic signed [ZW:0] sum;
		logic signed [ZW:0] r;
		logic signed [ZW:0] one;
		one = (ZW+1)'(1) <<< FRAC;
		sum = (ZW+1)'(v) + ((RND_SH > 0) ? ((ZW+1)'(1) <<< (RND_SH - 1)) : '0);
		r   = sum >>> RND_SH;
		if (r > one)
			r = one;
		if (r < -one)
			r = -one;
		return r[ENTRY_WIDTH-1:0];
	endfunction

endpackage

/* design/e2hm_if.sv */
// Handshake channel interfaces: pose in, transform out.
// Depends on e2hm_pkg.
interface e2hm_pose_if import e2hm_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] yaw;
	logic signed [ANGLE_W-1:0] pitch;
	logic signed [ANGLE_W-1:0] roll;
	logic signed [SHIFT_W-1:0] shift_x;
	logic signed [SHIFT_W-1:0] shift_y;
	logic signed [SHIFT_W-1:0] shift_z;

	modport source (output valid, yaw, pitch, roll, shift_x, shift_y, shift_z, input ready);
	modport sink   (input valid, yaw, pitch, roll, shift_x, shift_y, shift_z, output ready);
endinterface

interface e2hm_matrix_if import e2hm_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic signed [ENTRY_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [SHIFT_W-1:0]     offset_x;
	logic signed [SHIFT_W-1:0]     offset_y;
	logic signed [SHIFT_W-1:0]     offset_z;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		offset_x, offset_y, offset_z, input ready);
	modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		offset_x, offset_y, offset_z, output ready);
endinterface

/* design/e2hm_cordic_cell.sv */
// One CORDIC micro-rotation for all three angle lanes, registered.
// Depends on e2hm_pkg.
module e2hm_cordic_cell import e2hm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [STAGE_W-1:0]  stage,
	input  logic                valid_in,
	input  cordic_word_t        d,
	output logic                valid_q,
	output cordic_word_t        q
);
	cordic_word_t nxt;

	always_comb begin
		nxt = d;
		for (int k = 0; k < NLANE; k++) begin
			if (!d.lane[k].z[ZW-1]) begin
				nxt.lane[k].x = d.lane[k].x - (d.lane[k].y >>> stage);
				nxt.lane[k].y = d.lane[k].y + (d.lane[k].x >>> stage);
				nxt.lane[k].z = d.lane[k].z - atan_q30(stage);
			end else begin
				nxt.lane[k].x = d.lane[k].x + (d.lane[k].y >>> stage);
				nxt.lane[k].y = d.lane[k].y - (d.lane[k].x >>> stage);
				nxt.lane[k].z = d.lane[k].z + atan_q30(stage);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end
endmodule

/* design/e2hm_matrix.sv */
// Sign fix of sin/cos, two product stages and round/saturate to entries.
// Depends on e2hm_pkg and e2hm_matrix_if.
module e2hm_matrix import e2hm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  cordic_word_t        d,
	e2hm_matrix_if.source       res
);
	logic [3:0] vld_q;

	logic signed [SCW-1:0] sn_s1 [NLANE];
	logic signed [SCW-1:0] cs_s1 [NLANE];
	logic [NLANE-1:0][SHIFT_W-1:0] sh_s1, sh_s2, sh_s3;

	logic signed [SCW-1:0] cycp_s2, sycp_s2, cpsr_s2, cpcr_s2, cysp_s2, sysp_s2;
	logic signed [SCW-1:0] sycr_s2, sysr_s2, cycr_s2, cysr_s2, sp_s2, sr_s2, cr_s2;

	logic signed [SCW-1:0] cycp_s3, sycp_s3, cpsr_s3, cpcr_s3, sp_s3;
	logic signed [SCW-1:0] sycr_s3, sysr_s3, cycr_s3, cysr_s3;
	logic signed [SCW-1:0] t1_s3, t2_s3, t3_s3, t4_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[2:0], valid_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// fold back the half-turn range reduction
			for (int k = 0; k < NLANE; k++) begin
				sn_s1[k] <= d.neg[k] ? SCW'(-d.lane[k].y) : SCW'(d.lane[k].y);
				cs_s1[k] <= d.neg[k] ? SCW'(-d.lane[k].x) : SCW'(d.lane[k].x);
			end
			sh_s1 <= d.shift;

			cycp_s2 <= qmul(cs_s1[LANE_YAW], cs_s1[LANE_PITCH]);
			sycp_s2 <= qmul(sn_s1[LANE_YAW], cs_s1[LANE_PITCH]);
			cpsr_s2 <= qmul(cs_s1[LANE_PITCH], sn_s1[LANE_ROLL]);
			cpcr_s2 <= qmul(cs_s1[LANE_PITCH], cs_s1[LANE_ROLL]);
			cysp_s2 <= qmul(cs_s1[LANE_YAW], sn_s1[LANE_PITCH]);
			sysp_s2 <= qmul(sn_s1[LANE_YAW], sn_s1[LANE_PITCH]);
			sycr_s2 <= qmul(sn_s1[LANE_YAW], cs_s1[LANE_ROLL]);
			sysr_s2 <= qmul(sn_s1[LANE_YAW], sn_s1[LANE_ROLL]);
			cycr_s2 <= qmul(cs_s1[LANE_YAW], cs_s1[LANE_ROLL]);
			cysr_s2 <= qmul(cs_s1[LANE_YAW], sn_s1[LANE_ROLL]);
			sp_s2   <= sn_s1[LANE_PITCH];
			sr_s2   <= sn_s1[LANE_ROLL];
			cr_s2   <= cs_s1[LANE_ROLL];
			sh_s2   <= sh_s1;

			t1_s3   <= qmul(cysp_s2, sr_s2);
			t2_s3   <= qmul(cysp_s2, cr_s2);
			t3_s3   <= qmul(sysp_s2, sr_s2);
			t4_s3   <= qmul(sysp_s2, cr_s2);
			cycp_s3 <= cycp_s2;
			sycp_s3 <= sycp_s2;
			cpsr_s3 <= cpsr_s2;
			cpcr_s3 <= cpcr_s2;
			sp_s3   <= sp_s2;
			sycr_s3 <= sycr_s2;
			sysr_s3 <= sysr_s2;
			cycr_s3 <= cycr_s2;
			cysr_s3 <= cysr_s2;
			sh_s3   <= sh_s2;

			res.m00 <= to_entry(ZW'(cycp_s3));
			res.m01 <= to_entry(ZW'(t1_s3) - ZW'(sycr_s3));
			res.m02 <= to_entry(ZW'(t2_s3) + ZW'(sysr_s3));
			res.m10 <= to_entry(ZW'(sycp_s3));
			res.m11 <= to_entry(ZW'(t3_s3) + ZW'(cycr_s3));
			res.m12 <= to_entry(ZW'(t4_s3) - ZW'(cysr_s3));
			res.m20 <= to_entry(-ZW'(sp_s3));
			res.m21 <= to_entry(ZW'(cpsr_s3));
			res.m22 <= to_entry(ZW'(cpcr_s3));
			res.offset_x <= sh_s3[0];
			res.offset_y <= sh_s3[1];
			res.offset_z <= sh_s3[2];
		end
	end

	assign res.valid = vld_q[3];
endmodule

/* design/euler_to_homogeneous_matrix.sv */
// Z-Y-X Euler pose to the upper three rows of a homogeneous transform.
// Pipeline: one input stage, one cell per CORDIC stage, then sign fix,
// two multiply stages, output register.
// Throughput: one pose per cycle; the whole pipeline stalls only while a
// result sits unaccepted in the output register.
// Reset clears the valid bits only; datapath registers are not reset.
module euler_to_homogeneous_matrix import e2hm_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	e2hm_pose_if.sink      pose,
	e2hm_matrix_if.source  matrix
);
	// Global advance: move when the output register is empty or being drained.
	logic en;
	assign en         = !matrix.valid || matrix.ready;
	assign pose.ready = en;

	// ---- input stage: clamp, widen to Q30, fold into +-pi/2 ----
	logic signed [ANGLE_W-1:0] ang [NLANE];
	cordic_word_t              prep;
	cordic_word_t              prep_q;
	logic                      prep_vld_q;

	always_comb begin
		ang[LANE_YAW]   = pose.yaw;
		ang[LANE_PITCH] = pose.pitch;
		ang[LANE_ROLL]  = pose.roll;
		prep = '0;
		for (int k = 0; k < NLANE; k++) begin
			logic signed [ANGLE_W-1:0] a;
			logic signed [ZW-1:0]      z;
			a = ang[k];
			if (a > ANGLE_LIMIT)
				a = ANGLE_LIMIT;
			if (a < -ANGLE_LIMIT)
				a = -ANGLE_LIMIT;
			z = ZW'(a) <<< 17;
			prep.neg[k] = 1'b0;
			if (z > Q30_HALF_PI) begin
				z = z - Q30_PI;
				prep.neg[k] = 1'b1;
			end else if (z < -Q30_HALF_PI) begin
				z = z + Q30_PI;
				prep.neg[k] = 1'b1;
			end
			prep.lane[k].x = Q30_GAIN_INV;
			prep.lane[k].y = '0;
			prep.lane[k].z = z;
		end
		prep.shift[0] = pose.shift_x;
		prep.shift[1] = pose.shift_y;
		prep.shift[2] = pose.shift_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prep_vld_q <= 1'b0;
		end else if (en) begin
			prep_vld_q <= pose.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_q <= prep;
		end
	end

	// ---- CORDIC row: one cell per micro-rotation ----
	cordic_word_t       cw  [NSTG+1];
	logic [NSTG:0]      cv;

	assign cw[0] = prep_q;
	assign cv[0] = prep_vld_q;

	for (genvar g = 0; g < NSTG; g++) begin : g_cell
		e2hm_cordic_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.stage    (STAGE_W'(g)),
			.valid_in (cv[g]),
			.d        (cw[g]),
			.valid_q  (cv[g+1]),
			.q        (cw[g+1])
		);
	end

	// ---- products, rounding, output register ----
	e2hm_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (cv[NSTG]),
		.d        (cw[NSTG]),
		.res      (matrix)
	);
endmodule
